// File: rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the stereo biquad cascade.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbq_pkg;

   // Fixed formats: delay word width, guard bits below the sample LSB,
   // integer bits of a coefficient (sign included)
   localparam int DELAY_BITS = 48;
   localparam int GUARD_FRAC = 12;
   localparam int COEF_INT   = 5;

   localparam int NUM_COEFS  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int STAGE_CNT_W = 3;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_B0     = 3'd0,
      REG_B1     = 3'd1,
      REG_B2     = 3'd2,
      REG_A1     = 3'd3,
      REG_A2     = 3'd4,
      REG_STAGES = 3'd5
   } csr_reg_type;

   // Per-lane sequencer: six steps per biquad stage
   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_B0,
      LANE_Y,
      LANE_A1,
      LANE_B2,
      LANE_A2,
      LANE_D1,
      LANE_FIN
   } lane_state_type;

   // Lane status toward top level and merge stage
   typedef struct packed {
      logic busy;
      logic done;
      logic clip;
   } lane_status_type;

endpackage

// File: rtl/sbq_lane.sv
// ----------------------------------------------------------------------------
// sbq_lane
// One channel of the cascade: a single shared multiplier steps through all
// stages, keeping the two delay words of every stage in registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbq_lane
   import sbq_pkg::*;
#(
   parameter int MAX_STAGES  = 4,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  logic                                 start,
   input  logic [$clog2(MAX_STAGES+1)-1:0]      num_stages,
   input  logic [NUM_COEFS-1:0][COEF_BITS-1:0]  coefs,
   input  logic [SAMPLE_BITS-1:0]               x_in,
   output logic [SAMPLE_BITS-1:0]               y_out,
   output lane_status_type                      status
);

   localparam int PW         = COEF_BITS + SAMPLE_BITS;
   localparam int PROD_SHIFT = COEF_BITS - COEF_INT - GUARD_FRAC;
   localparam int SCL_W      = PW - PROD_SHIFT;
   localparam int SUM_W      = ((SCL_W > DELAY_BITS) ? SCL_W : DELAY_BITS) + 2;
   localparam int SIDX_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int CNT_W      = $clog2(MAX_STAGES + 1);
   localparam int YTOP       = GUARD_FRAC + SAMPLE_BITS - 1;

   lane_state_type state_ff, state_in;

   logic [SIDX_W-1:0]        stage_ff;
   logic [CNT_W-1:0]         num_ff;
   logic [SAMPLE_BITS-1:0]   x_ff;
   logic [SAMPLE_BITS-1:0]   y_ff;
   logic                     clip_ff;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic [SUM_W-1:0]         t_ff;
   logic [DELAY_BITS-1:0]    d0_ff [MAX_STAGES];
   logic [DELAY_BITS-1:0]    d1_ff [MAX_STAGES];

   logic [CSR_IDX_W-1:0]     coef_idx;
   logic                     use_y;
   logic                     last_stage;
   logic [COEF_BITS-1:0]     coef_sel;
   logic [SAMPLE_BITS-1:0]   smp_sel;
   logic [SUM_W-1:0]         scl_ext;
   logic [SUM_W-1:0]         d0_ext;
   logic [SUM_W-1:0]         d1_ext;
   logic [SUM_W-1:0]         acc;
   logic [SUM_W-1:0]         diff;
   logic                     y_ovf;
   logic [SAMPLE_BITS-1:0]   y_sat;
   logic                     d_ovf;
   logic [DELAY_BITS-1:0]    d_sat;

   assign last_stage = (CNT_W'(stage_ff) == (num_ff - CNT_W'(1)));

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and multiplier operand selection
   always_comb begin
      state_in = state_ff;
      coef_idx = REG_B0;
      use_y    = 1'b0;
      unique case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               state_in = (num_stages == '0) ? LANE_FIN : LANE_B0;
            end
         end
         LANE_B0: begin
            coef_idx = REG_B0;
            state_in = LANE_Y;
         end
         LANE_Y: begin
            coef_idx = REG_B1;
            state_in = LANE_A1;
         end
         LANE_A1: begin
            coef_idx = REG_A1;
            use_y    = 1'b1;
            state_in = LANE_B2;
         end
         LANE_B2: begin
            coef_idx = REG_B2;
            state_in = LANE_A2;
         end
         LANE_A2: begin
            coef_idx = REG_A2;
            use_y    = 1'b1;
            state_in = LANE_D1;
         end
         LANE_D1: begin
            state_in = last_stage ? LANE_FIN : LANE_B0;
         end
         LANE_FIN: begin
            state_in = LANE_IDLE;
         end
         default: begin
            state_in = LANE_IDLE;
         end
      endcase
   end

   // Shared multiplier, product registered
   assign coef_sel = coefs[coef_idx];
   assign smp_sel  = use_y ? y_ff : x_ff;
   assign prod_in  = $signed(coef_sel) * $signed(smp_sel);

   // Scaled product and delay words in the wide sum format
   assign scl_ext = {{(SUM_W-SCL_W){prod_ff[PW-1]}}, prod_ff[PW-1:PROD_SHIFT]};
   assign d0_ext  = {{(SUM_W-DELAY_BITS){d0_ff[stage_ff][DELAY_BITS-1]}}, d0_ff[stage_ff]};
   assign d1_ext  = {{(SUM_W-DELAY_BITS){d1_ff[stage_ff][DELAY_BITS-1]}}, d1_ff[stage_ff]};

   // Stage output: floor to sample LSB, then saturate
   assign acc   = scl_ext + d0_ext;
   assign y_ovf = !((&acc[SUM_W-1:YTOP]) || !(|acc[SUM_W-1:YTOP]));
   assign y_sat = y_ovf ? {acc[SUM_W-1], {(SAMPLE_BITS-1){~acc[SUM_W-1]}}}
                        : acc[YTOP:GUARD_FRAC];

   // New delay word: partial sum minus feedback product, saturated
   assign diff  = t_ff - scl_ext;
   assign d_ovf = !((&diff[SUM_W-1:DELAY_BITS-1]) || !(|diff[SUM_W-1:DELAY_BITS-1]));
   assign d_sat = d_ovf ? {diff[SUM_W-1], {(DELAY_BITS-1){~diff[SUM_W-1]}}}
                        : diff[DELAY_BITS-1:0];

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               x_ff     <= x_in;
               num_ff   <= num_stages;
               stage_ff <= '0;
               clip_ff  <= 1'b0;
            end
         end
         LANE_Y: begin
            y_ff    <= y_sat;
            clip_ff <= clip_ff | y_ovf;
         end
         LANE_A1: begin
            t_ff <= scl_ext + d1_ext;
         end
         LANE_A2: begin
            t_ff <= scl_ext;
         end
         LANE_D1: begin
            x_ff     <= y_ff;
            stage_ff <= stage_ff + SIDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Delay state, cleared at reset and on a stage count write
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < MAX_STAGES; i++) begin
            d0_ff[i] <= '0;
            d1_ff[i] <= '0;
         end
      end else if (state_ff == LANE_B2) begin
         d0_ff[stage_ff] <= d_sat;
      end else if (state_ff == LANE_D1) begin
         d1_ff[stage_ff] <= d_sat;
      end
   end

   assign y_out       = x_ff;
   assign status.busy = (state_ff != LANE_IDLE);
   assign status.done = (state_ff == LANE_FIN);
   assign status.clip = clip_ff;

endmodule

// File: rtl/sbq_merge.sv
// ----------------------------------------------------------------------------
// sbq_merge
// Joins the two lane results into one response and holds it in an output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbq_merge
   import sbq_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [SAMPLE_BITS-1:0]  left_y,
   input  logic [SAMPLE_BITS-1:0]  right_y,
   input  lane_status_type         left_st,
   input  lane_status_type         right_st,
   input  logic                    out_ready,
   output logic                    out_valid,
   output logic [SAMPLE_BITS-1:0]  out_left,
   output logic [SAMPLE_BITS-1:0]  out_right,
   output logic                    out_clip,
   output logic                    pending
);

   logic                    have_l_ff, have_r_ff;
   logic [SAMPLE_BITS-1:0]  l_ff, r_ff;
   logic                    lclip_ff, rclip_ff;
   logic                    valid_ff;
   logic [SAMPLE_BITS-1:0]  out_l_ff, out_r_ff;
   logic                    out_clip_ff;

   logic                    both;
   logic                    out_free;
   logic                    move;
   logic [SAMPLE_BITS-1:0]  l_cur, r_cur;
   logic                    clip_cur;

   assign both     = (have_l_ff || left_st.done) && (have_r_ff || right_st.done);
   assign out_free = !valid_ff || out_ready;
   assign move     = both && out_free;
   assign l_cur    = left_st.done  ? left_y  : l_ff;
   assign r_cur    = right_st.done ? right_y : r_ff;
   assign clip_cur = (left_st.done  ? left_st.clip  : lclip_ff) |
                     (right_st.done ? right_st.clip : rclip_ff);

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         have_l_ff <= 1'b0;
         have_r_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (move) begin
            have_l_ff <= 1'b0;
            have_r_ff <= 1'b0;
         end else begin
            if (left_st.done)  have_l_ff <= 1'b1;
            if (right_st.done) have_r_ff <= 1'b1;
         end
         if (move) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Lane results waiting for their partner, and the output register
   always_ff @(posedge clock) begin
      if (left_st.done) begin
         l_ff     <= left_y;
         lclip_ff <= left_st.clip;
      end
      if (right_st.done) begin
         r_ff     <= right_y;
         rclip_ff <= right_st.clip;
      end
      if (move) begin
         out_l_ff    <= l_cur;
         out_r_ff    <= r_cur;
         out_clip_ff <= clip_cur;
      end
   end

   assign out_valid = valid_ff;
   assign out_left  = out_l_ff;
   assign out_right = out_r_ff;
   assign out_clip  = out_clip_ff;
   assign pending   = have_l_ff || have_r_ff;

endmodule

// File: rtl/stereo_biquad_cascade.sv
// ----------------------------------------------------------------------------
// stereo_biquad_cascade
// Stereo cascade of identical transposed direct form II biquads, one lane
// per channel, with software loaded coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one stereo pair (left in the low half of req_tdata).
//   rsp_* returns the filtered pair and a clip flag in rsp_tuser.
//   csr_* writes a register: index 0..4 are b0, b1, b2, a1, a2 (Q4.27),
//   index 5 the stage count; other indexes are ignored. Writing the stage
//   count clears all delay state. csr_ready is always high; write only
//   while no request is in flight.
// Flow:
//   Each lane runs its stages one after another on one shared multiplier.
//   A request is taken only while both lanes are idle and no lane result
//   waits in the merge, so the next pair is accepted only after the lanes
//   have finished the previous one.
// Reset clears the delay state, sets b0 to 1.0, the other taps to 0 and
// the stage count to 0 (bypass). A stalled receiver holds the response in
// the output register; one further request is still taken and finished,
// then req_tready stays low until the held response leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_biquad_cascade
   import sbq_pkg::*;
#(
   parameter int MAX_STAGES  = 4,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: left_sample, right_sample, zero fill
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // fields from bit 0: left_out, right_out, zero fill
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   // fields from bit 0: clipped
   output logic                                   rsp_tuser,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [COEF_BITS-1:0]                   csr_data
);

   localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int CNT_W  = $clog2(MAX_STAGES + 1);

   // Tap values after reset: b0 = 1.0, all other taps zero
   localparam logic [NUM_COEFS-1:0][COEF_BITS-1:0] COEF_RESET =
      (NUM_COEFS*COEF_BITS)'(COEF_BITS'(1) << (COEF_BITS - COEF_INT))
         << (int'(REG_B0) * COEF_BITS);

   logic [NUM_COEFS-1:0][COEF_BITS-1:0]  coef_ff;
   logic [STAGE_CNT_W-1:0]               stage_count_ff;
   logic                                 clear_ff;

   logic [CNT_W-1:0]        num_stages;
   logic                    accept;
   logic                    csr_write;
   logic                    pending;
   logic                    rsp_clip;
   logic [SAMPLE_BITS-1:0]  left_y, right_y;
   logic [SAMPLE_BITS-1:0]  rsp_left, rsp_right;
   lane_status_type         left_st, right_st;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff           <= COEF_RESET;
         stage_count_ff    <= '0;
         clear_ff          <= 1'b0;
      end else begin
         clear_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_reg_type'(csr_index))
               REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
                  coef_ff[csr_index] <= csr_data;
               end
               REG_STAGES: begin
                  stage_count_ff <= csr_data[STAGE_CNT_W-1:0];
                  clear_ff       <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Stage counts above the build limit run the full cascade
   assign num_stages = (int'(stage_count_ff) > MAX_STAGES) ? CNT_W'(MAX_STAGES)
                                                           : CNT_W'(stage_count_ff);

   // Take a request once both lanes are free and the merge holds no waiting lane result
   assign req_tready = !left_st.busy && !right_st.busy && !pending;
   assign accept     = req_tvalid && req_tready;

   sbq_lane #(
      .MAX_STAGES  (MAX_STAGES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_left (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear_ff),
      .start      (accept),
      .num_stages (num_stages),
      .coefs      (coef_ff),
      .x_in       (req_tdata[SAMPLE_BITS-1:0]),
      .y_out      (left_y),
      .status     (left_st)
   );

   sbq_lane #(
      .MAX_STAGES  (MAX_STAGES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_right (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear_ff),
      .start      (accept),
      .num_stages (num_stages),
      .coefs      (coef_ff),
      .x_in       (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .y_out      (right_y),
      .status     (right_st)
   );

   sbq_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .left_y    (left_y),
      .right_y   (right_y),
      .left_st   (left_st),
      .right_st  (right_st),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_left  (rsp_left),
      .out_right (rsp_right),
      .out_clip  (rsp_clip),
      .pending   (pending)
   );

   assign rsp_tdata = DATA_W'({rsp_right, rsp_left});
   assign rsp_tuser = rsp_clip;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo biquad cascade.
// ----------------------------------------------------------------------------
// A queue of stereo pairs feeds a clocked driver on the req_ stream. Every
// accepted pair runs through a fixed-point filter predictor kept in step with
// the register writes. The monitor compares each response field by field
// with the oldest prediction. Directed pairs cover bypass, saturation,
// stage-count clamping and ignored register indexes. Random phases then vary
// the coefficients, the stage count and the pacing on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import sbq_pkg::*;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int MAX_STAGES = 4;
   localparam int DATA_W     = ((2*SAMPLE_W+7)/8)*8;
   localparam int COEF_FRAC  = COEF_W - COEF_INT;
   localparam int PROD_SHIFT = COEF_FRAC - GUARD_FRAC;
   localparam longint SMAX   = (64'sd1 <<< (SAMPLE_W-1)) - 1;
   localparam longint SMIN   = -(64'sd1 <<< (SAMPLE_W-1));
   localparam longint DMAX   = (64'sd1 <<< (DELAY_BITS-1)) - 1;
   localparam longint DMIN   = -(64'sd1 <<< (DELAY_BITS-1));
   localparam int COEF_ONE   = 1 << COEF_FRAC;
   localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [COEF_W-1:0] C_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] C_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   // indexes past the register map; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
   localparam int RANDOM_PHASES  = 20;
   localparam int PAIRS_PER_PHASE = 60;
   localparam int DRAIN_CYCLES   = 40;
   localparam int STALL_LIMIT    = 4000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                clip;
   } filtered_pair_type;

   // DUT connections, all inputs known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]    csr_data = '0;

   // predictor copy of registers and delay lines
   longint coef_model [NUM_COEFS];
   logic [STAGE_CNT_W-1:0] stages_model;
   longint first_delay_model [2*MAX_STAGES];
   longint second_delay_model [2*MAX_STAGES];

   logic [DATA_W-1:0]  sample_pairs [$];
   filtered_pair_type  filtered_q [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int pairs_sent = 0;
   int pairs_checked = 0;
   int clips_seen = 0;
   int settings_used = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   logic load_next;

   stereo_biquad_cascade i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // coefficient times sample, floored into the delay format
   function automatic longint tap_product(longint c, longint s);
      return (c * s) >>> PROD_SHIFT;
   endfunction

   function automatic longint clamp_delay(longint v);
      if (v > DMAX) return DMAX;
      if (v < DMIN) return DMIN;
      return v;
   endfunction

   function automatic void clear_delays();
      int i;
      for (i = 0; i < 2*MAX_STAGES; i++) begin
         first_delay_model[i] = 0;
         second_delay_model[i] = 0;
      end
   endfunction

   // runs one pair through the cascade and advances the delay lines
   function automatic filtered_pair_type filter_pair(logic [DATA_W-1:0] pair);
      filtered_pair_type r;
      longint x, y, acc;
      int n, ch, j, k;
      r = '0;
      n = (stages_model > MAX_STAGES) ? MAX_STAGES : int'(stages_model);
      for (ch = 0; ch < 2; ch++) begin
         x = longint'($signed(pair[ch*SAMPLE_W +: SAMPLE_W]));
         for (j = 0; j < n; j++) begin
            k = 2*j + ch;
            acc = tap_product(coef_model[REG_B0], x) + first_delay_model[k];
            y = acc >>> GUARD_FRAC;
            if (y > SMAX) begin
               y = SMAX;
               r.clip = 1'b1;
            end
            if (y < SMIN) begin
               y = SMIN;
               r.clip = 1'b1;
            end
            first_delay_model[k] = clamp_delay(tap_product(coef_model[REG_B1], x)
               - tap_product(coef_model[REG_A1], y) + second_delay_model[k]);
            second_delay_model[k] = clamp_delay(tap_product(coef_model[REG_B2], x)
               - tap_product(coef_model[REG_A2], y));
            x = y;
         end
         if (ch == 0) r.left = x[SAMPLE_W-1:0];
         else r.right = x[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // mirror of a register write
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      case (csr_reg_type'(idx))
         REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
            coef_model[idx] = longint'($signed(value));
         end
         REG_STAGES: begin
            stages_model = value[STAGE_CNT_W-1:0];
            clear_delays();
         end
         default: ;
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      apply_reg(idx, value);
      csr_valid <= 1'b0;
   endtask

   function automatic void queue_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
      sample_pairs.push_back({r, l});
   endfunction

   // wait at the falling edge until every pair has been answered
   task automatic drain();
      do @(negedge clock);
      while (sample_pairs.size() != 0 || req_tvalid || filtered_q.size() != 0);
   endtask

   task automatic set_pacing(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
         default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
   endtask

   // mostly moderate taps within +-span, some full range and extremes
   function automatic logic [COEF_W-1:0] pick_coef(int unsigned span);
      logic [COEF_W-1:0] v;
      case ($urandom_range(9))
         0: v = $urandom;
         1: v = $urandom_range(1) ? C_MAX : C_MIN;
         default: v = $urandom_range(2*span) - span;
      endcase
      return v;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [31:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: v = S_MAX;
               1: v = S_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
         1: v = $urandom_range(511) - 256;
         default: v = $urandom;
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // request driver: predicts on acceptance, then presents the next pair
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         load_next = !req_tvalid;
         if (req_tvalid && req_tready) begin
            filtered_q.push_back(filter_pair(req_tdata));
            pairs_sent++;
            load_next = 1'b1;
         end
         if (load_next) begin
            if (sample_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= sample_pairs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and watchdog
   always @(posedge clock) begin
      filtered_pair_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               mismatches++;
               $display("%0t: response expected none actual %h/%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = filtered_q.pop_front();
               pairs_checked++;
               if (want.clip) clips_seen++;
               if (rsp_tdata[SAMPLE_W-1:0] !== want.left) begin
                  mismatches++;
                  $display("%0t: left_out expected %h actual %h", $time,
                           want.left, rsp_tdata[SAMPLE_W-1:0]);
               end
               if (rsp_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.right) begin
                  mismatches++;
                  $display("%0t: right_out expected %h actual %h", $time,
                           want.right, rsp_tdata[2*SAMPLE_W-1:SAMPLE_W]);
               end
               if (rsp_tuser !== want.clip) begin
                  mismatches++;
                  $display("%0t: clipped expected %b actual %b", $time,
                           want.clip, rsp_tuser);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      int p, i;
      coef_model[REG_B0] = COEF_ONE;
      coef_model[REG_B1] = 0;
      coef_model[REG_B2] = 0;
      coef_model[REG_A1] = 0;
      coef_model[REG_A2] = 0;
      stages_model = '0;
      clear_delays();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_pacing(0);

      // bypass after reset: outputs follow inputs, never clipped
      settings_used++;
      queue_pair(S_MAX, S_MIN);
      queue_pair(S_MIN, S_MAX);
      queue_pair('0, '0);
      queue_pair('1, 24'd1);
      queue_pair(24'h555555, 24'haaaaaa);
      drain();

      // largest positive gain, one stage: saturates both ways
      write_reg(REG_B0, C_MAX);
      write_reg(REG_STAGES, 32'd1);
      settings_used++;
      queue_pair(S_MAX, S_MIN);
      queue_pair(24'd1, '1);
      queue_pair('0, '0);
      queue_pair(24'h100000, 24'hf00000);
      drain();

      // extreme taps everywhere, full cascade: delay lines saturate
      write_reg(REG_B0, C_MIN);
      write_reg(REG_B1, C_MAX);
      write_reg(REG_B2, C_MIN);
      write_reg(REG_A1, C_MIN);
      write_reg(REG_A2, C_MAX);
      write_reg(REG_STAGES, 32'd4);
      write_reg(IDX_SPARE_LO, 32'hdeadbeef);
      write_reg(IDX_SPARE_HI, C_MAX);
      settings_used++;
      queue_pair(S_MAX, S_MAX);
      queue_pair(S_MIN, S_MAX);
      queue_pair(S_MIN, S_MIN);
      queue_pair('0, '0);
      queue_pair('0, '0);
      drain();

      // stage count above the maximum clamps to four; impulse response
      write_reg(REG_B0, COEF_ONE / 2);
      write_reg(REG_B1, COEF_ONE / 4);
      write_reg(REG_B2, -(COEF_ONE / 8));
      write_reg(REG_A1, -(COEF_ONE / 2));
      write_reg(REG_A2, COEF_ONE / 4);
      write_reg(REG_STAGES, 32'd7);
      settings_used++;
      queue_pair(S_MAX, S_MIN);
      for (i = 0; i < 4; i++) queue_pair('0, '0);
      drain();

      // unity cascade with stage count five
      write_reg(REG_B0, COEF_ONE);
      write_reg(REG_B1, '0);
      write_reg(REG_B2, '0);
      write_reg(REG_A1, '0);
      write_reg(REG_A2, '0);
      write_reg(REG_STAGES, 32'd5);
      settings_used++;
      queue_pair(S_MAX, S_MIN);
      queue_pair(S_MIN, S_MAX);
      queue_pair(24'h123456, 24'hedcba9);
      drain();

      // random phases: new taps, often a new stage count, rotating pacing
      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_pacing(p % 4);
         if ($urandom_range(3) != 0) write_reg(REG_B0, pick_coef(COEF_ONE));
         if ($urandom_range(3) != 0) write_reg(REG_B1, pick_coef(COEF_ONE));
         if ($urandom_range(3) != 0) write_reg(REG_B2, pick_coef(COEF_ONE));
         if ($urandom_range(3) != 0) write_reg(REG_A1, pick_coef(COEF_ONE / 2));
         if ($urandom_range(3) != 0) write_reg(REG_A2, pick_coef(COEF_ONE / 2));
         if ($urandom_range(9) < 7)
            write_reg(REG_STAGES, ($urandom_range(3) == 0) ? $urandom_range(7)
                                                          : $urandom_range(1, 4));
         if ($urandom_range(4) == 0)
            write_reg($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom);
         settings_used++;
         for (i = 0; i < PAIRS_PER_PHASE; i++) queue_pair(pick_sample(), pick_sample());
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d stereo pairs under %0d register settings;", pairs_sent,
               settings_used);
      $display("%0d responses checked, %0d of them clipped.", pairs_checked, clips_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/sbq_pkg.sv
rtl/sbq_lane.sv
rtl/sbq_merge.sv
rtl/stereo_biquad_cascade.sv
bench/testbench.sv
